FILE: rtl/hgv_pkg.sv
// Package: shared types, constants and corner tables of the hex grid vertex generator.
package hgv_pkg;

  localparam int CountW = 6;
  localparam int SizeW  = 16;
  localparam int RowW   = 48;
  localparam int CoordW = 7;
  localparam int PosW   = 24;
  localparam int IdxW   = 3;
  localparam int OpAW   = 44;
  localparam int OpBW   = 18;
  localparam int AccW   = 62;

  // sqrt(3) in Q1.16
  localparam logic signed [OpBW-1:0] Sq3Q16 = 18'sd113512;

  localparam logic [IdxW-1:0] CfgCountX  = 3'd0;
  localparam logic [IdxW-1:0] CfgCountY  = 3'd1;
  localparam logic [IdxW-1:0] CfgCountZ  = 3'd2;
  localparam logic [IdxW-1:0] CfgCellSz  = 3'd3;
  localparam logic [IdxW-1:0] CfgRowX    = 3'd4;
  localparam logic [IdxW-1:0] CfgRowY    = 3'd5;
  localparam logic [IdxW-1:0] CfgRowZ    = 3'd6;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_CALC,
    T_OUT
  } top_state_e;

  typedef enum logic {
    SC_IDLE,
    SC_RUN
  } scan_state_e;

  typedef struct packed {
    logic                     done;
    logic                     found;
    logic signed [CoordW-1:0] q;
    logic signed [CoordW-1:0] r;
  } scan_rsp_t;

  // Corner offsets in units of s/2 along x and s*sqrt3/2 along z
  function automatic logic signed [2:0] corner_dx(input logic [IdxW-1:0] k);
    logic signed [2:0] v;
    case (k)
      3'd0:    v = 3'sd2;
      3'd1:    v = 3'sd1;
      3'd2:    v = -3'sd1;
      3'd3:    v = -3'sd2;
      3'd4:    v = -3'sd1;
      3'd5:    v = 3'sd1;
      default: v = 3'sd2;
    endcase
    return v;
  endfunction

  function automatic logic signed [2:0] corner_dz(input logic [IdxW-1:0] k);
    logic signed [2:0] v;
    case (k)
      3'd1, 3'd2: v = 3'sd1;
      3'd4, 3'd5: v = -3'sd1;
      default:    v = 3'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/hgv_mac.sv
// Shared multiply-add unit with registered result.
module hgv_mac import hgv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [OpAW-1:0] op_a_i,
  input  logic signed [OpBW-1:0] op_b_i,
  input  logic signed [AccW-1:0] addend_i,
  output logic signed [AccW-1:0] res_o
);

  logic signed [AccW-1:0] res_q, res_d;

  // Multiply and add in one step
  always_comb begin
    res_d = AccW'(op_a_i * op_b_i) + addend_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: rtl/hgv_scan.sv
// Cell scanner: walks scan positions one per cycle to the next kept cell.
module hgv_scan import hgv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              restart_i,
  input  logic [CountW-1:0] count_x_i,
  input  logic [CountW-1:0] count_y_i,
  input  logic [CountW-1:0] count_z_i,
  output scan_rsp_t         rsp_o
);

  scan_state_e state_q, state_d;
  logic signed [7:0] q_q, q_d, r_q, r_d;
  logic started_q, started_d, fin_q, fin_d;

  logic signed [7:0] cx, cy, ncx, ncy;
  logic signed [8:0] sum, abs_sum;
  logic below_q, past_q, past_r, below_r, keep;

  assign cx  = $signed({2'b00, count_x_i});
  assign cy  = $signed({2'b00, count_y_i});
  assign ncx = -cx;
  assign ncy = -cy;
  assign sum = 9'(q_q) + 9'(r_q);
  assign abs_sum = sum[8] ? -sum : sum;

  assign below_q = q_q < ncx;
  assign past_q  = q_q > cx;
  assign past_r  = r_q > cy;
  assign below_r = r_q < ncy;
  assign keep    = abs_sum <= $signed({3'b000, count_z_i});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SC_IDLE: if (start_i) state_d = SC_RUN;
      SC_RUN: begin
        if (!below_q && (past_q || (!past_r && !below_r && keep))) state_d = SC_IDLE;
      end
      default: state_d = SC_IDLE;
    endcase
  end

  // Response
  always_comb begin
    rsp_o.done  = 1'b0;
    rsp_o.found = 1'b0;
    rsp_o.q     = q_q[CoordW-1:0];
    rsp_o.r     = r_q[CoordW-1:0];
    unique case (state_q)
      SC_IDLE: ;
      SC_RUN: begin
        if (!below_q && past_q) begin
          rsp_o.done = 1'b1;
        end else if (!below_q && !past_r && !below_r && keep) begin
          rsp_o.done  = 1'b1;
          rsp_o.found = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Position and scan state
  always_comb begin
    q_d = q_q;
    r_d = r_q;
    started_d = started_q;
    fin_d = fin_q;
    if (state_q == SC_IDLE) begin
      if (start_i) begin
        if (restart_i || !started_q) begin
          started_d = 1'b1;
          q_d = ncx;
          r_d = ncy;
        end else if (fin_q) begin
          q_d = 8'sd127;
        end else begin
          r_d = r_q + 8'sd1;
        end
      end
    end else begin
      if (below_q) begin
        q_d = ncx;
        r_d = ncy;
      end else if (past_q) begin
        fin_d = 1'b1;
      end else if (past_r) begin
        r_d = ncy;
        q_d = q_q + 8'sd1;
      end else if (below_r) begin
        r_d = ncy;
      end else if (keep) begin
        fin_d = 1'b0;
      end else begin
        r_d = r_q + 8'sd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SC_IDLE;
      q_q       <= '0;
      r_q       <= '0;
      started_q <= 1'b0;
      fin_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      q_q       <= q_d;
      r_q       <= r_d;
      started_q <= started_d;
      fin_q     <= fin_d;
    end
  end

endmodule

FILE: rtl/hex_grid_cell_vertex_generator.sv
// Top level: configuration registers, point sequencer and result register.
//
// Usage: each transfer on the input channel (restart_i = 1 restarts the scan,
// 0 advances) makes the block find the next kept hex cell and produce eight
// result transfers: the cell centre, then corners 0..6 (corner 6 closes the
// ring). last_o marks the eighth. When no cell remains a single result with
// finished_o = 1 and last_o = 1 and zero point fields is produced instead.
// The scanner tries one scan position per cycle while searching for a cell.
// Each point is then computed on the shared multiply-add unit, one output
// row at a time, with four multiply steps and a rounding/saturation step
// per row, and is held in the result register until it is taken.
// in_ready_o is high only while the block is idle. A stalled receiver holds
// the result register and the sequencer until the transfer completes. Reset
// clears the scan to its not-started state and loads the default
// configuration (counts 4, cell size 1.0, identity rows). The configuration
// port always accepts.
module hex_grid_cell_vertex_generator import hgv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IdxW-1:0]          cfg_index_i,
  input  logic [RowW-1:0]          cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     restart_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     point_kind_o,
  output logic [IdxW-1:0]          corner_index_o,
  output logic signed [CoordW-1:0] cell_q_o,
  output logic signed [CoordW-1:0] cell_r_o,
  output logic signed [PosW-1:0]   pos_x_o,
  output logic signed [PosW-1:0]   pos_y_o,
  output logic signed [PosW-1:0]   pos_z_o,
  output logic                     last_o,
  output logic                     finished_o
);

  logic [CountW-1:0] count_x_q, count_y_q, count_z_q;
  logic [SizeW-1:0]  cell_size_q;
  logic [RowW-1:0]   row_x_q, row_y_q, row_z_q;

  top_state_e state_q, state_d;
  logic [2:0] pt_q;
  logic [1:0] row_q;
  logic [2:0] step_q;
  logic       fin_q;
  logic signed [CoordW-1:0] cq_q, cr_q;
  logic signed [OpAW-1:0]   t_q;
  logic signed [PosW-1:0]   pos_x_q, pos_y_q, pos_z_q;

  logic in_xfer, out_xfer, cfg_xfer, scan_start;
  scan_rsp_t scan_rsp;

  logic [RowW-1:0] row_sel;
  logic signed [9:0] a_val, b_val;
  logic signed [2:0] dx, dz;
  logic [IdxW-1:0] ck;
  logic mac_en;
  logic signed [OpAW-1:0] op_a;
  logic signed [OpBW-1:0] op_b;
  logic signed [AccW-1:0] addend, mac_res;
  logic signed [30:0] hi;
  logic signed [PosW-1:0] sat;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;
  assign scan_start  = in_xfer;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_x_q   <= 6'd4;
      count_y_q   <= 6'd4;
      count_z_q   <= 6'd4;
      cell_size_q <= 16'd256;
      row_x_q     <= 48'd16384;
      row_y_q     <= 48'd0;
      row_z_q     <= 48'd1073741824;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        CfgCountX: count_x_q   <= cfg_data_i[CountW-1:0];
        CfgCountY: count_y_q   <= cfg_data_i[CountW-1:0];
        CfgCountZ: count_z_q   <= cfg_data_i[CountW-1:0];
        CfgCellSz: cell_size_q <= cfg_data_i[SizeW-1:0];
        CfgRowX:   row_x_q     <= cfg_data_i;
        CfgRowY:   row_y_q     <= cfg_data_i;
        CfgRowZ:   row_z_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hgv_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .restart_i (restart_i),
    .count_x_i (count_x_q),
    .count_y_i (count_y_q),
    .count_z_i (count_z_q),
    .rsp_o     (scan_rsp)
  );

  // Local point factors: x = s/2 * a, z = s*sqrt3/2 * b
  assign ck    = pt_q - 3'd1;
  assign dx    = (pt_q == 3'd0) ? 3'sd0 : corner_dx(ck);
  assign dz    = (pt_q == 3'd0) ? 3'sd0 : corner_dz(ck);
  assign a_val = 10'(cq_q) * 10'sd3 + 10'(dx);
  assign b_val = 10'(cr_q) * 10'sd2 + 10'(cq_q) + 10'(dz);

  always_comb begin
    case (row_q)
      2'd0:    row_sel = row_x_q;
      2'd1:    row_sel = row_y_q;
      default: row_sel = row_z_q;
    endcase
  end

  // Operand selection for the shared unit
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    addend = '0;
    case (step_q)
      3'd0: begin
        op_a = OpAW'(a_val);
        op_b = OpBW'($signed(row_sel[15:0]));
      end
      3'd1: begin
        op_a = OpAW'(b_val);
        op_b = OpBW'($signed(row_sel[31:16]));
      end
      3'd2: begin
        op_a   = mac_res[OpAW-1:0];
        op_b   = Sq3Q16;
        addend = AccW'(t_q) <<< 16;
      end
      default: begin
        op_a   = mac_res[OpAW-1:0];
        op_b   = $signed({2'b00, cell_size_q});
        addend = (AccW'($signed(row_sel[47:32])) <<< 31) + (AccW'(1) <<< 30);
      end
    endcase
  end

  assign mac_en = (state_q == T_CALC) && (step_q < 3'd4);

  hgv_mac u_mac (
    .clk_i    (clk_i),
    .en_i     (mac_en),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .addend_i (addend),
    .res_o    (mac_res)
  );

  // Round to nearest at 31 bits, saturate to the position range
  assign hi = mac_res[AccW-1:31];
  always_comb begin
    if (hi > 31'sd8388607)       sat = 24'sh7FFFFF;
    else if (hi < -31'sd8388608) sat = 24'sh800000;
    else                         sat = hi[PosW-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:   if (in_xfer) state_d = T_SEARCH;
      T_SEARCH: if (scan_rsp.done) state_d = scan_rsp.found ? T_CALC : T_OUT;
      T_CALC:   if (step_q == 3'd4 && row_q == 2'd2) state_d = T_OUT;
      T_OUT: begin
        if (out_xfer) state_d = (fin_q || pt_q == 3'd7) ? T_IDLE : T_CALC;
      end
      default: state_d = T_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      T_IDLE:   in_ready_o  = 1'b1;
      T_SEARCH: ;
      T_CALC:   ;
      T_OUT:    out_valid_o = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      pt_q    <= '0;
      row_q   <= '0;
      step_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == T_SEARCH && scan_rsp.done) begin
        fin_q  <= !scan_rsp.found;
        pt_q   <= '0;
        row_q  <= '0;
        step_q <= '0;
      end else if (state_q == T_CALC) begin
        if (step_q == 3'd4) begin
          step_q <= '0;
          row_q  <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end else if (state_q == T_OUT && out_xfer && !fin_q && pt_q != 3'd7) begin
        pt_q <= pt_q + 3'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == T_SEARCH && scan_rsp.done) begin
      cq_q <= scan_rsp.found ? scan_rsp.q : '0;
      cr_q <= scan_rsp.found ? scan_rsp.r : '0;
      if (!scan_rsp.found) begin
        pos_x_q <= '0;
        pos_y_q <= '0;
        pos_z_q <= '0;
      end
    end
    if (state_q == T_CALC && step_q == 3'd1) begin
      t_q <= mac_res[OpAW-1:0];
    end
    if (state_q == T_CALC && step_q == 3'd4) begin
      case (row_q)
        2'd0:    pos_x_q <= sat;
        2'd1:    pos_y_q <= sat;
        default: pos_z_q <= sat;
      endcase
    end
  end

  assign point_kind_o   = !fin_q && (pt_q != 3'd0);
  assign corner_index_o = (fin_q || pt_q == 3'd0) ? 3'd0 : ck;
  assign cell_q_o       = cq_q;
  assign cell_r_o       = cr_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign pos_z_o        = pos_z_q;
  assign last_o         = fin_q || (pt_q == 3'd7);
  assign finished_o     = fin_q;

endmodule
